// ===== rtl/tdps_pkg.sv =====
// types, codes and helpers shared by the task scheduler modules
`timescale 1ns / 1ps
`default_nettype none

package tdps_pkg;

  // input transaction
  typedef struct packed {
    logic        action;
    logic [15:0] task_id;
    logic [2:0]  priority_level;
    logic [15:0] burst_count;
    logic [15:0] burst_length;
    logic [15:0] block_length;
    logic [31:0] arrival_tick;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic        add_rejected;
    logic        running_valid;
    logic [15:0] running_id;
    logic        exit_valid;
    logic [15:0] exit_id;
    logic [31:0] departure_tick;
    logic [31:0] ready_total;
    logic [31:0] run_total;
    logic [31:0] blocked_total;
    logic [31:0] turnaround;
  } out_item_t;

  // one entry of the task table
  typedef struct packed {
    logic [15:0] id;
    logic [2:0]  prio;
    logic [15:0] bursts_left;
    logic [15:0] burst_len;
    logic [15:0] block_len;
    logic [31:0] arrival;
    logic [31:0] entered;
    logic [2:0]  phase;
    logic [31:0] t_ready;
    logic [31:0] t_run;
    logic [31:0] t_blocked;
  } task_rec_t;

  // task phase codes
  localparam logic [2:0] PH_NEW   = 3'd0;
  localparam logic [2:0] PH_READY = 3'd1;
  localparam logic [2:0] PH_RUN   = 3'd2;
  localparam logic [2:0] PH_BLOCK = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;

  // action codes
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // ready queue indexes
  localparam logic [1:0] Q_TOP = 2'd0;
  localparam logic [1:0] Q_MID = 2'd1;
  localparam logic [1:0] Q_BOT = 2'd2;

  // operations of the shared record update unit
  typedef enum logic [1:0] {
    OP_AGE    = 2'd0,
    OP_WAKE   = 2'd1,
    OP_ARRIVE = 2'd2,
    OP_RUN    = 2'd3
  } ev_op_e;

  // status from the record update unit
  typedef struct packed {
    logic        push;
    logic [1:0]  qsel;
    logic        halt;
    logic        blk;
    logic [31:0] turn;
  } ev_res_t;

  // ready queue for a priority under the given mode
  function automatic logic [1:0] queue_sel(input logic [2:0] prio, input logic mode);
    logic [1:0] q;
    q = Q_TOP;
    if (mode) begin
      if (prio == 3'd1) q = Q_TOP;
      else if (prio == 3'd2) q = Q_MID;
      else q = Q_BOT;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tdps_eval.sv =====
// shared record update unit: aging, wake-up, arrival and dispatch of one task
`timescale 1ns / 1ps
`default_nettype none

module tdps_eval (
  input  tdps_pkg::ev_op_e    op_i,
  input  tdps_pkg::task_rec_t rec_i,
  input  logic [31:0]         now_i,
  input  logic                mode_i,
  output tdps_pkg::task_rec_t rec_o,
  output tdps_pkg::ev_res_t   res_o
);
  import tdps_pkg::*;

  logic [31:0] diff;
  logic        hit_burst;
  logic        hit_block;

  // ticks since the task entered its phase
  assign diff      = now_i - rec_i.entered;
  assign hit_burst = (diff == {16'd0, rec_i.burst_len});
  assign hit_block = (diff == {16'd0, rec_i.block_len});

  // per-operation record update
  always_comb begin
    rec_o      = rec_i;
    res_o      = '0;
    res_o.qsel = queue_sel(rec_i.prio, mode_i);
    res_o.turn = now_i - rec_i.arrival;
    unique case (op_i)
      OP_AGE: begin
        case (rec_i.phase)
          PH_READY: rec_o.t_ready = rec_i.t_ready + 32'd1;
          PH_RUN: begin
            rec_o.t_run = rec_i.t_run + 32'd1;
            if (hit_burst) rec_o.bursts_left = rec_i.bursts_left - 16'd1;
            if (rec_o.bursts_left == 16'd0) begin
              res_o.halt    = 1'b1;
              rec_o.phase   = PH_DONE;
              rec_o.entered = now_i;
            end else if (hit_burst) begin
              res_o.blk     = 1'b1;
              rec_o.phase   = PH_BLOCK;
              rec_o.entered = now_i;
            end
          end
          PH_BLOCK: begin
            rec_o.t_blocked = rec_i.t_blocked + 32'd1;
            if (hit_block) rec_o.phase = PH_READY;
          end
          default: ;
        endcase
      end
      OP_WAKE: begin
        if (rec_i.phase != PH_BLOCK) begin
          rec_o.phase   = PH_READY;
          rec_o.entered = now_i;
          res_o.push    = 1'b1;
        end
      end
      OP_ARRIVE: begin
        if (rec_i.phase == PH_NEW && rec_i.arrival == now_i) begin
          rec_o.phase   = PH_READY;
          rec_o.entered = now_i;
          res_o.push    = 1'b1;
        end
      end
      OP_RUN: begin
        rec_o.phase   = PH_RUN;
        rec_o.entered = now_i;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/tdps_rdyq.sv =====
// three ready queues of task slots in one ring memory
`timescale 1ns / 1ps
`default_nettype none

module tdps_rdyq #(
  parameter int MAX_TASKS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [1:0]                    push_q_i,
  input  logic [$clog2(MAX_TASKS)-1:0]  push_slot_i,
  input  logic                          pop_i,
  input  logic [1:0]                    pop_q_i,
  output logic [$clog2(MAX_TASKS)-1:0]  pop_slot_o,
  output logic [2:0]                    nonempty_o
);
  localparam int IW     = $clog2(MAX_TASKS);
  localparam int QDEPTH = 3 * (1 << IW);

  logic [IW-1:0] qmem [0:QDEPTH-1];
  logic [IW-1:0] head_q [3];
  logic [IW-1:0] tail_q [3];
  logic [IW:0]   len_q  [3];
  logic [IW-1:0] pop_slot_q;

  // queue memory, registered read
  always_ff @(posedge clk_i) begin
    if (push_i) qmem[{push_q_i, tail_q[push_q_i]}] <= push_slot_i;
    if (pop_i) pop_slot_q <= qmem[{pop_q_i, head_q[pop_q_i]}];
  end

  // ring pointers and fill counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < 3; q++) begin
        head_q[q] <= '0;
        tail_q[q] <= '0;
        len_q[q]  <= '0;
      end
    end else begin
      for (int q = 0; q < 3; q++) begin
        if (push_i && push_q_i == 2'(q) && !(pop_i && pop_q_i == 2'(q))) begin
          len_q[q] <= len_q[q] + (IW+1)'(1);
        end else if (pop_i && pop_q_i == 2'(q) && !(push_i && push_q_i == 2'(q))) begin
          len_q[q] <= len_q[q] - (IW+1)'(1);
        end
        if (push_i && push_q_i == 2'(q)) tail_q[q] <= tail_q[q] + IW'(1);
        if (pop_i && pop_q_i == 2'(q)) head_q[q] <= head_q[q] + IW'(1);
      end
    end
  end

  assign pop_slot_o = pop_slot_q;
  always_comb begin
    for (int q = 0; q < 3; q++) nonempty_o[q] = (len_q[q] != '0);
  end

endmodule

`default_nettype wire

// ===== rtl/tick_driven_priority_task_scheduler_top.sv =====
// tick-driven non-preemptive task scheduler: sequencer, task table and blocked list
// add transaction: the record is written to the table on accept, then the result is loaded from S_FIN
// tick transaction: aging pass over the table, blocked list rebuild, arrival pass, then a dispatch
//   from the ready queues when the cpu is idle; every task record is walked twice, for aging and
//   for arrivals, through the task-table read port
// one transaction at a time; the next is accepted while a result waits; async low reset clears state
`timescale 1ns / 1ps
`default_nettype none

module tick_driven_priority_task_scheduler_top #(
  parameter int MAX_TASKS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tdps_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tdps_pkg::out_item_t out_data_o
);
  import tdps_pkg::*;

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = IW + 1;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_AGE   = 4'd1;
  localparam logic [3:0] S_BRD   = 4'd2;
  localparam logic [3:0] S_BSLOT = 4'd3;
  localparam logic [3:0] S_BEVAL = 4'd4;
  localparam logic [3:0] S_BTAIL = 4'd5;
  localparam logic [3:0] S_ARR   = 4'd6;
  localparam logic [3:0] S_DSP   = 4'd7;
  localparam logic [3:0] S_DSP2  = 4'd8;
  localparam logic [3:0] S_DSP3  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0]    state_q, state_d;
  logic [31:0]   tick_q, tick_d;
  logic [CW-1:0] count_q, count_d;
  logic          mode_q;
  logic          tick_item_q, tick_item_d;
  logic          rej_q, rej_d;
  logic          run_valid_q, run_valid_d;
  logic [IW-1:0] run_slot_q, run_slot_d;
  logic [15:0]   run_id_q, run_id_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          pend_q, pend_d;
  logic [IW-1:0] pidx_q, pidx_d;
  logic          ex_q, ex_d;
  logic [15:0]   ex_id_q, ex_id_d;
  logic [31:0]   ex_ready_q, ex_ready_d;
  logic [31:0]   ex_run_q, ex_run_d;
  logic [31:0]   ex_blk_q, ex_blk_d;
  logic [31:0]   ex_turn_q, ex_turn_d;
  logic          bank_q, bank_d;
  logic [CW-1:0] blen_q, blen_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] k_q, k_d;
  logic          ins_q, ins_d;
  logic [IW-1:0] ins_slot_q, ins_slot_d;
  logic [15:0]   ins_id_q, ins_id_d;
  logic          out_valid_q;
  out_item_t     out_q;
  logic          out_load;

  // task table
  task_rec_t     tmem [0:MAX_TASKS-1];
  task_rec_t     tm_rdata_q;
  logic          tm_re, tm_we;
  logic [IW-1:0] tm_raddr, tm_waddr;
  task_rec_t     tm_wdata;

  // blocked list, two banks
  logic [IW-1:0] blist [0:(2 << IW)-1];
  logic [IW-1:0] bl_rdata_q;
  logic          bl_re, bl_we;
  logic [IW-1:0] bl_wdata;

  // shared update unit
  ev_op_e        ev_op;
  task_rec_t     ev_rec;
  ev_res_t       ev_res;

  // ready queues
  logic          q_push, q_pop;
  logic [1:0]    q_push_sel, q_pop_sel;
  logic [IW-1:0] q_push_slot, q_pop_slot;
  logic [2:0]    q_nonempty;

  task_rec_t     new_rec;

  tdps_eval u_eval (
    .op_i   (ev_op),
    .rec_i  (tm_rdata_q),
    .now_i  (tick_q),
    .mode_i (mode_q),
    .rec_o  (ev_rec),
    .res_o  (ev_res)
  );

  tdps_rdyq #(.MAX_TASKS(MAX_TASKS)) u_rdyq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_q_i    (q_push_sel),
    .push_slot_i (q_push_slot),
    .pop_i       (q_pop),
    .pop_q_i     (q_pop_sel),
    .pop_slot_o  (q_pop_slot),
    .nonempty_o  (q_nonempty)
  );

  // record built from an add transaction
  always_comb begin
    new_rec             = '0;
    new_rec.id          = in_data_i.task_id;
    new_rec.prio        = in_data_i.priority_level;
    new_rec.bursts_left = in_data_i.burst_count;
    new_rec.burst_len   = in_data_i.burst_length;
    new_rec.block_len   = in_data_i.block_length;
    new_rec.arrival     = in_data_i.arrival_tick;
    new_rec.phase       = PH_NEW;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_load   = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d     = state_q;
    tick_d      = tick_q;
    count_d     = count_q;
    tick_item_d = tick_item_q;
    rej_d       = rej_q;
    run_valid_d = run_valid_q;
    run_slot_d  = run_slot_q;
    run_id_d    = run_id_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    ex_d        = ex_q;
    ex_id_d     = ex_id_q;
    ex_ready_d  = ex_ready_q;
    ex_run_d    = ex_run_q;
    ex_blk_d    = ex_blk_q;
    ex_turn_d   = ex_turn_q;
    bank_d      = bank_q;
    blen_d      = blen_q;
    j_d         = j_q;
    k_d         = k_q;
    ins_d       = ins_q;
    ins_slot_d  = ins_slot_q;
    ins_id_d    = ins_id_q;
    tm_re       = 1'b0;
    tm_raddr    = '0;
    tm_we       = 1'b0;
    tm_waddr    = '0;
    tm_wdata    = ev_rec;
    bl_re       = 1'b0;
    bl_we       = 1'b0;
    bl_wdata    = bl_rdata_q;
    ev_op       = OP_AGE;
    q_push      = 1'b0;
    q_push_sel  = ev_res.qsel;
    q_push_slot = pidx_q;
    q_pop       = 1'b0;
    q_pop_sel   = Q_TOP;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ex_d        = 1'b0;
          rej_d       = 1'b0;
          ins_d       = 1'b0;
          idx_d       = '0;
          pend_d      = 1'b0;
          tick_item_d = (in_data_i.action == ACT_TICK);
          if (in_data_i.action == ACT_TICK) begin
            state_d = S_AGE;
          end else begin
            state_d = S_FIN;
            if (count_q == CW'(MAX_TASKS)) begin
              rej_d = 1'b1;
            end else begin
              tm_we    = 1'b1;
              tm_waddr = count_q[IW-1:0];
              tm_wdata = new_rec;
              count_d  = count_q + CW'(1);
            end
          end
        end
      end

      // age every stored task, one read and one write-back a cycle
      S_AGE: begin
        ev_op = OP_AGE;
        if (pend_q) begin
          tm_we    = 1'b1;
          tm_waddr = pidx_q;
          if (ev_res.halt) begin
            ex_d        = 1'b1;
            ex_id_d     = tm_rdata_q.id;
            ex_ready_d  = tm_rdata_q.t_ready;
            ex_run_d    = ev_rec.t_run;
            ex_blk_d    = tm_rdata_q.t_blocked;
            ex_turn_d   = ev_res.turn;
            run_valid_d = 1'b0;
          end
          if (ev_res.blk) begin
            ins_d       = 1'b1;
            ins_slot_d  = pidx_q;
            ins_id_d    = tm_rdata_q.id;
            run_valid_d = 1'b0;
          end
        end
        if (idx_q < count_q) begin
          tm_re    = 1'b1;
          tm_raddr = idx_q[IW-1:0];
          idx_d    = idx_q + CW'(1);
          pend_d   = 1'b1;
          pidx_d   = idx_q[IW-1:0];
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            j_d     = '0;
            k_d     = '0;
            state_d = (blen_q == '0) ? S_BTAIL : S_BRD;
          end
        end
      end

      // blocked list rebuild: read entry, read its task, then place it
      S_BRD: begin
        bl_re   = 1'b1;
        state_d = S_BSLOT;
      end

      S_BSLOT: begin
        tm_re    = 1'b1;
        tm_raddr = bl_rdata_q;
        state_d  = S_BEVAL;
      end

      S_BEVAL: begin
        ev_op = OP_WAKE;
        if (ins_q && tm_rdata_q.id > ins_id_q) begin
          // newly blocked task goes in front of the first larger id
          bl_we    = 1'b1;
          bl_wdata = ins_slot_q;
          k_d      = k_q + CW'(1);
          ins_d    = 1'b0;
        end else begin
          if (ev_res.push) begin
            tm_we       = 1'b1;
            tm_waddr    = bl_rdata_q;
            q_push      = 1'b1;
            q_push_slot = bl_rdata_q;
          end else begin
            bl_we    = 1'b1;
            bl_wdata = bl_rdata_q;
            k_d      = k_q + CW'(1);
          end
          j_d     = j_q + CW'(1);
          state_d = (j_q + CW'(1) == blen_q) ? S_BTAIL : S_BRD;
        end
      end

      S_BTAIL: begin
        if (ins_q) begin
          bl_we    = 1'b1;
          bl_wdata = ins_slot_q;
        end
        blen_d  = k_q + CW'(ins_q);
        ins_d   = 1'b0;
        bank_d  = ~bank_q;
        idx_d   = '0;
        pend_d  = 1'b0;
        state_d = S_ARR;
      end

      // arrivals in table order
      S_ARR: begin
        ev_op = OP_ARRIVE;
        if (pend_q && ev_res.push) begin
          tm_we    = 1'b1;
          tm_waddr = pidx_q;
          q_push   = 1'b1;
        end
        if (idx_q < count_q) begin
          tm_re    = 1'b1;
          tm_raddr = idx_q[IW-1:0];
          idx_d    = idx_q + CW'(1);
          pend_d   = 1'b1;
          pidx_d   = idx_q[IW-1:0];
        end else begin
          pend_d = 1'b0;
          if (!pend_q) state_d = S_DSP;
        end
      end

      // idle cpu takes the head of the highest non-empty queue
      S_DSP: begin
        if (run_valid_q || q_nonempty == 3'b000) begin
          state_d = S_FIN;
        end else begin
          q_pop = 1'b1;
          if (q_nonempty[0]) q_pop_sel = Q_TOP;
          else if (q_nonempty[1]) q_pop_sel = Q_MID;
          else q_pop_sel = Q_BOT;
          state_d = S_DSP2;
        end
      end

      S_DSP2: begin
        tm_re      = 1'b1;
        tm_raddr   = q_pop_slot;
        run_slot_d = q_pop_slot;
        state_d    = S_DSP3;
      end

      S_DSP3: begin
        ev_op       = OP_RUN;
        tm_we       = 1'b1;
        tm_waddr    = run_slot_q;
        run_valid_d = 1'b1;
        run_id_d    = tm_rdata_q.id;
        state_d     = S_FIN;
      end

      S_FIN: begin
        if (out_load) begin
          if (tick_item_q) tick_d = tick_q + 32'd1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // task table and blocked list memories
  always_ff @(posedge clk_i) begin
    if (tm_we) tmem[tm_waddr] <= tm_wdata;
    if (tm_re) tm_rdata_q <= tmem[tm_raddr];
    if (bl_we) blist[{~bank_q, k_q[IW-1:0]}] <= bl_wdata;
    if (bl_re) bl_rdata_q <= blist[{bank_q, j_q[IW-1:0]}];
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.add_rejected   <= rej_q;
      out_q.running_valid  <= run_valid_q;
      out_q.running_id     <= run_valid_q ? run_id_q : 16'd0;
      out_q.exit_valid     <= ex_q;
      out_q.exit_id        <= ex_q ? ex_id_q : 16'd0;
      out_q.departure_tick <= ex_q ? tick_q : 32'd0;
      out_q.ready_total    <= ex_q ? ex_ready_q : 32'd0;
      out_q.run_total      <= ex_q ? ex_run_q : 32'd0;
      out_q.blocked_total  <= ex_q ? ex_blk_q : 32'd0;
      out_q.turnaround     <= ex_q ? ex_turn_q : 32'd0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tick_q      <= '0;
      count_q     <= '0;
      mode_q      <= 1'b0;
      tick_item_q <= 1'b0;
      rej_q       <= 1'b0;
      run_valid_q <= 1'b0;
      run_slot_q  <= '0;
      run_id_q    <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      pidx_q      <= '0;
      ex_q        <= 1'b0;
      ex_id_q     <= '0;
      ex_ready_q  <= '0;
      ex_run_q    <= '0;
      ex_blk_q    <= '0;
      ex_turn_q   <= '0;
      bank_q      <= 1'b0;
      blen_q      <= '0;
      j_q         <= '0;
      k_q         <= '0;
      ins_q       <= 1'b0;
      ins_slot_q  <= '0;
      ins_id_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      count_q     <= count_d;
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      tick_item_q <= tick_item_d;
      rej_q       <= rej_d;
      run_valid_q <= run_valid_d;
      run_slot_q  <= run_slot_d;
      run_id_q    <= run_id_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      pidx_q      <= pidx_d;
      ex_q        <= ex_d;
      ex_id_q     <= ex_id_d;
      ex_ready_q  <= ex_ready_d;
      ex_run_q    <= ex_run_d;
      ex_blk_q    <= ex_blk_d;
      ex_turn_q   <= ex_turn_d;
      bank_q      <= bank_d;
      blen_q      <= blen_d;
      j_q         <= j_d;
      k_q         <= k_d;
      ins_q       <= ins_d;
      ins_slot_q  <= ins_slot_d;
      ins_id_q    <= ins_id_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== tb/tick_driven_priority_task_scheduler_top_tb.sv =====
// testbench for the tick-driven task scheduler: shadow scheduler scoreboard and staged tests
`timescale 1ns / 1ps
`default_nettype none

module tick_driven_priority_task_scheduler_top_tb;
  import tdps_pkg::*;

  localparam int NTASK = 256;
  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_HALT  = 2'd1;
  localparam logic [1:0] REQ_BLOCK = 2'd2;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic      cfg_wdata_i = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  tick_driven_priority_task_scheduler_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // scheduler shadow state
  logic        mode_sh;
  logic [31:0] tick_sh;
  int          ntasks_sh;
  logic [15:0] t_id [NTASK];
  logic [2:0]  t_prio [NTASK];
  logic [15:0] t_left [NTASK];
  logic [15:0] t_blen [NTASK];
  logic [15:0] t_klen [NTASK];
  logic [31:0] t_arr [NTASK];
  logic [31:0] t_ent [NTASK];
  logic [2:0]  t_ph [NTASK];
  logic [1:0]  t_req [NTASK];
  logic [31:0] t_rdy [NTASK];
  logic [31:0] t_run [NTASK];
  logic [31:0] t_blk [NTASK];
  int          ready_q [3][$];
  int          blocked_q [$];
  logic        cpu_busy;
  int          cpu_slot;

  out_item_t   pending_results [$];
  int          errors = 0;
  int          n_items = 0, n_checked = 0, n_exits = 0, n_rejects = 0;
  int          idle_pct = 0, stall_pct = 0, hold_left = 0;

  task automatic enter_phase(int s, logic [2:0] ph);
    t_ph[s] = ph;
    t_req[s] = REQ_NONE;
    t_ent[s] = tick_sh;
  endtask

  task automatic make_ready(int s);
    logic [1:0] q;
    enter_phase(s, PH_READY);
    q = Q_TOP;
    if (mode_sh) q = (t_prio[s] == 3'd1) ? Q_TOP : (t_prio[s] == 3'd2) ? Q_MID : Q_BOT;
    ready_q[q].insert(ready_q[q].size(), s);
  endtask

  // advance the shadow scheduler by one transaction and return its result
  task automatic sched_step(input in_item_t it, output out_item_t r);
    logic [31:0] now;
    int pos, ex_slot;
    int keep [$];
    r = '0;
    now = tick_sh;
    ex_slot = -1;
    if (it.action == ACT_ADD) begin
      if (ntasks_sh >= NTASK) begin
        r.add_rejected = 1'b1;
      end else begin
        t_id[ntasks_sh] = it.task_id;      t_prio[ntasks_sh] = it.priority_level;
        t_left[ntasks_sh] = it.burst_count; t_blen[ntasks_sh] = it.burst_length;
        t_klen[ntasks_sh] = it.block_length; t_arr[ntasks_sh] = it.arrival_tick;
        t_ent[ntasks_sh] = '0; t_ph[ntasks_sh] = PH_NEW; t_req[ntasks_sh] = REQ_NONE;
        t_rdy[ntasks_sh] = '0; t_run[ntasks_sh] = '0; t_blk[ntasks_sh] = '0;
        ntasks_sh++;
      end
    end else begin
      // aging pass
      for (int i = 0; i < ntasks_sh; i++) begin
        if (t_ph[i] == PH_READY) begin
          t_rdy[i]++;
        end else if (t_ph[i] == PH_RUN) begin
          t_run[i]++;
          if (now - t_ent[i] == 32'(t_blen[i])) begin
            t_req[i] = REQ_BLOCK;
            t_left[i] = t_left[i] - 16'd1;
          end
          if (t_left[i] == 16'd0) begin
            t_req[i] = REQ_HALT;
            ex_slot = i;
          end
        end else if (t_ph[i] == PH_BLOCK) begin
          t_blk[i]++;
          if (now - t_ent[i] == 32'(t_klen[i])) t_ph[i] = PH_READY;
        end
      end
      // running task leaves or blocks
      if (cpu_busy) begin
        if (t_req[cpu_slot] == REQ_HALT) begin
          enter_phase(cpu_slot, PH_DONE);
          cpu_busy = 1'b0;
        end else if (t_req[cpu_slot] == REQ_BLOCK) begin
          enter_phase(cpu_slot, PH_BLOCK);
          pos = 0;
          while (pos < blocked_q.size() && t_id[blocked_q[pos]] <= t_id[cpu_slot]) pos++;
          blocked_q.insert(pos, cpu_slot);
          cpu_busy = 1'b0;
        end
      end
      // wake expired blocked tasks in list order
      foreach (blocked_q[k]) begin
        if (t_ph[blocked_q[k]] != PH_BLOCK) make_ready(blocked_q[k]);
        else keep.insert(keep.size(), blocked_q[k]);
      end
      blocked_q = keep;
      // arrivals
      for (int i = 0; i < ntasks_sh; i++)
        if (t_ph[i] == PH_NEW && t_arr[i] == now) make_ready(i);
      // dispatch
      if (!cpu_busy) begin
        for (int q = 0; q < 3; q++) begin
          if (!cpu_busy && ready_q[q].size() != 0) begin
            cpu_slot = ready_q[q].pop_front();
            enter_phase(cpu_slot, PH_RUN);
            cpu_busy = 1'b1;
          end
        end
      end
      tick_sh = now + 32'd1;
    end
    r.running_valid = cpu_busy;
    r.running_id = cpu_busy ? t_id[cpu_slot] : 16'd0;
    if (ex_slot >= 0) begin
      r.exit_valid = 1'b1;
      r.exit_id = t_id[ex_slot];
      r.departure_tick = now;
      r.ready_total = t_rdy[ex_slot];
      r.run_total = t_run[ex_slot];
      r.blocked_total = t_blk[ex_slot];
      r.turnaround = now - t_arr[ex_slot];
    end
  endtask

  // receiver: random stalls, or a counted hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (e.exit_valid) n_exits++;
        if (e.add_rejected) n_rejects++;
        if (out_data_o.add_rejected !== e.add_rejected ||
            out_data_o.running_valid !== e.running_valid ||
            out_data_o.running_id !== e.running_id ||
            out_data_o.exit_valid !== e.exit_valid ||
            out_data_o.exit_id !== e.exit_id ||
            out_data_o.departure_tick !== e.departure_tick ||
            out_data_o.ready_total !== e.ready_total ||
            out_data_o.run_total !== e.run_total ||
            out_data_o.blocked_total !== e.blocked_total ||
            out_data_o.turnaround !== e.turnaround) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, out_data_o);
          errors++;
        end
      end
    end
  end

  // offer one transaction, wait for acceptance, then predict it
  task automatic send_item(input in_item_t it);
    out_item_t r;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sched_step(it, r);
    pending_results.insert(pending_results.size(), r);
    n_items++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mode_sh = m;
  endtask

  function automatic in_item_t mk_add(logic [15:0] id, logic [2:0] pr, logic [15:0] bc,
                                      logic [15:0] bl, logic [15:0] kl, logic [31:0] at);
    in_item_t it;
    it = '{ACT_ADD, id, pr, bc, bl, kl, at};
    return it;
  endfunction

  function automatic in_item_t mk_tick();
    in_item_t it;
    it = '{ACT_TICK, 16'($urandom), 3'($urandom), 16'($urandom), 16'($urandom),
           16'($urandom), $urandom};
    return it;
  endfunction

  // random items, mostly ticks; adds are mostly well-formed tasks that arrive soon and run short bursts
  function automatic in_item_t rand_item();
    logic [15:0] bc, bl;
    if ($urandom_range(0, 99) >= 40) return mk_tick();
    bc = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    bl = (bc == 0 && $urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4));
    return mk_add(($urandom_range(0, 1) ? 16'($urandom_range(0, 15)) : 16'($urandom)),
                  3'($urandom_range(0, 7)), bc, bl,
                  ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 5)) : 16'($urandom),
                  ($urandom_range(0, 99) < 85) ? tick_sh + $urandom_range(0, 6) : $urandom);
  endfunction

  task automatic test_directed();
    send_item(mk_add(16'hFFFF, 3'd7, 16'd2, 16'd1, 16'd1, 32'd0));
    send_item(mk_add(16'h0000, 3'd0, 16'd0, 16'hFFFF, 16'hFFFF, 32'd1));
    send_item(mk_add(16'h0005, 3'd1, 16'd1, 16'd2, 16'd0, 32'd0));
    send_item(mk_add(16'h0005, 3'd2, 16'd1, 16'd1, 16'd3, 32'd2));
    send_item(mk_add(16'h1234, 3'd3, 16'd2, 16'd1, 16'd0, 32'hFFFF_FFFF));
    send_item(mk_add(16'h0003, 3'd1, 16'hFFFF, 16'd1, 16'd1, 32'd4));
    repeat (14) send_item(mk_tick());
    drain();
  endtask

  task automatic test_priority();
    write_mode(1'b1);
    for (int p = 0; p < 8; p++)
      send_item(mk_add(16'(100 - p), 3'(p), 16'd1, 16'd1, 16'd1, tick_sh + 32'd1));
    repeat (12) send_item(mk_tick());
    drain();
  endtask

  task automatic test_random(input int n, input int ip, input int sp, input logic m);
    idle_pct = ip;
    stall_pct = sp;
    write_mode(m);
    repeat (n) send_item(rand_item());
    drain();
  endtask

  // receiver holds off while items keep coming, so the input stalls
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    @(negedge clk_i);
    hold_left = 300;
    repeat (12) send_item(rand_item());
    drain();
  endtask

  task automatic test_full_table();
    while (ntasks_sh < NTASK)
      send_item(mk_add(16'($urandom), 3'($urandom), 16'($urandom_range(0, 2)),
                       16'($urandom_range(1, 3)), 16'($urandom_range(0, 3)),
                       tick_sh + $urandom_range(0, 20)));
    repeat (3) send_item(mk_add(16'hFFFF, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    repeat (40) send_item(rand_item());
    drain();
  endtask

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    mode_sh = 1'b0;
    tick_sh = '0;
    ntasks_sh = 0;
    cpu_busy = 1'b0;
    cpu_slot = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_priority();
    test_random(80, 0, 0, 1'b0);
    test_backpressure();
    test_random(80, 62, 0, 1'b1);
    test_random(60, 0, 62, 1'b0);
    test_random(60, 33, 33, 1'b1);
    test_full_table();
    test_random(80, 33, 33, 1'b0);
    repeat (50) @(posedge clk_i);
    $display("covered %0d transactions in both queue modes, %0d results checked", n_items,
             n_checked);
    $display("%0d task exits and %0d rejected adds seen", n_exits, n_rejects);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== tick_driven_priority_task_scheduler_top.f =====
rtl/tdps_pkg.sv
rtl/tdps_eval.sv
rtl/tdps_rdyq.sv
rtl/tick_driven_priority_task_scheduler_top.sv
tb/tick_driven_priority_task_scheduler_top_tb.sv
